FILE: rtl/pcs_pkg.sv
// Shared types and constants for the periodic catch-up scheduler.
package pcs_pkg;

    localparam int TIME_W     = 40;
    localparam int INTERVAL_W = 32;
    localparam int MAXO_W     = 5;
    localparam int OUTST_W    = 8;
    localparam int SKIP_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [INTERVAL_W-1:0] interval_t;
    typedef logic [MAXO_W-1:0]     maxo_t;
    typedef logic [OUTST_W-1:0]    outst_t;
    typedef logic [SKIP_W-1:0]     skip_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_PERIOD_INTERVAL = 2'd0;
    localparam cfg_idx_t REG_MAX_OUTSTANDING = 2'd1;

    localparam skip_t BOUNDARY_CLAMP      = 30'd1000000000;
    localparam maxo_t MAX_OUTSTANDING_RST = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        time_t stamp_time;
        logic  stamp_valid;
        logic  last_of_poll;
        logic  rebased;
        skip_t skipped_count;
        time_t new_last_fired;
    } result_t;

endpackage

FILE: rtl/pcs_ifs.sv
// Handshake channel interfaces: poll input, result output, register writes.
interface pcs_poll_if import pcs_pkg::*; ();
    logic   valid;
    logic   ready;
    time_t  now_time;
    outst_t outstanding_count;

    modport source (output valid, output now_time, output outstanding_count, input ready);
    modport sink   (input valid, input now_time, input outstanding_count, output ready);
endinterface

interface pcs_result_if import pcs_pkg::*; ();
    logic  valid;
    logic  ready;
    time_t stamp_time;
    logic  stamp_valid;
    logic  last_of_poll;
    logic  rebased;
    skip_t skipped_count;
    time_t new_last_fired;

    modport source (output valid, output stamp_time, output stamp_valid, output last_of_poll,
                    output rebased, output skipped_count, output new_last_fired, input ready);
    modport sink   (input valid, input stamp_time, input stamp_valid, input last_of_poll,
                    input rebased, input skipped_count, input new_last_fired, output ready);
endinterface

interface pcs_cfg_if import pcs_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/periodic_catchup_scheduler.sv
// Periodic catch-up scheduler: serial divide of elapsed time, then stamp emission.
// A zero interval or a clock moved back skips the divider and gives only a status word.
// Otherwise the bit-serial divider runs first; a backlog over the clamp then adds a pass
// of the bit-serial multiplier. Results then leave one per cycle while result.ready is set.
// A new poll is accepted only once the last word of the previous poll has been issued.
// Reset: rst_n asynchronous active low; interval 0, max_outstanding 16, last-fired time 0.
module periodic_catchup_scheduler import pcs_pkg::*; #(
    parameter int QUEUE_LIMIT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    pcs_cfg_if.sink             cfg,
    pcs_poll_if.sink            poll,
    pcs_result_if.source        result
);

    localparam int CNT_W = $clog2(QUEUE_LIMIT + 1);
    localparam outst_t QLIM = OUTST_W'(QUEUE_LIMIT);

    state_t           state_reg;
    interval_t        period_interval_reg;
    maxo_t            max_outstanding_reg;
    time_t            last_fired_reg;
    time_t            now_reg;
    outst_t           outst_reg;
    time_t            newlast_reg;
    skip_t            skipped_reg;
    logic             rebased_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    time_t            stamp_reg;
    result_t          out_reg;
    logic             out_valid_reg;

    logic      accept;
    logic      zero_int;
    logic      backward;
    logic      div_start;
    logic      div_done;
    time_t     div_q;
    interval_t div_r;
    logic      mul_start;
    logic      mul_done;
    time_t     mul_p;

    logic      over;
    skip_t     bcl;
    outst_t    room_raw;
    outst_t    room_cap;
    skip_t     count_full;
    logic      slot_free;
    time_t     stamp_next;
    logic      last_stamp;

    assign accept    = poll.valid && poll.ready;
    assign zero_int  = period_interval_reg == '0;
    assign backward  = poll.now_time < last_fired_reg;
    assign div_start = accept && !zero_int && !backward;

    pcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (poll.now_time - last_fired_reg),
        .divisor   (period_interval_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign over = div_q > TIME_W'(BOUNDARY_CLAMP);
    assign bcl  = over ? BOUNDARY_CLAMP : div_q[SKIP_W-1:0];
    assign mul_start = (state_reg == ST_DIV) && div_done && over;

    pcs_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (period_interval_reg),
        .done         (mul_done),
        .product      (mul_p)
    );

    always_comb
    begin
        if (outst_reg >= OUTST_W'(max_outstanding_reg))
            room_raw = '0;
        else
            room_raw = OUTST_W'(max_outstanding_reg) - outst_reg;
        room_cap   = (room_raw > QLIM) ? QLIM : room_raw;
        count_full = (bcl < SKIP_W'(room_cap)) ? bcl : SKIP_W'(room_cap);
    end

    assign slot_free  = !out_valid_reg || result.ready;
    assign stamp_next = stamp_reg + TIME_W'(period_interval_reg);
    assign last_stamp = CNT_W'(idx_reg + 1'b1) == count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_interval_reg <= '0;
            max_outstanding_reg <= MAX_OUTSTANDING_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PERIOD_INTERVAL: period_interval_reg <= cfg.data[INTERVAL_W-1:0];
                REG_MAX_OUTSTANDING: max_outstanding_reg <= cfg.data[MAXO_W-1:0];
                default: ;
            endcase
        end
    end

    // control: state, stored time, emit counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_fired_reg <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= (zero_int || backward) ? ST_EMIT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        count_reg <= (div_q == '0) ? '0 : CNT_W'(count_full);
                        state_reg <= over ? ST_MUL : ST_EMIT;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        idx_reg       <= idx_reg + 1'b1;
                        if (count_reg == '0 || last_stamp)
                        begin
                            last_fired_reg <= newlast_reg;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // poll-wide payload and output word
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_reg     <= poll.now_time;
                    outst_reg   <= poll.outstanding_count;
                    stamp_reg   <= last_fired_reg;
                    skipped_reg <= '0;
                    rebased_reg <= !zero_int && backward;
                    newlast_reg <= (!zero_int && backward) ? poll.now_time : last_fired_reg;
                end
            end
            ST_DIV:
            begin
                if (div_done && div_q != '0)
                begin
                    skipped_reg <= bcl - count_full;
                    // exact case: boundary just below now is now minus the remainder
                    if (!over)
                        newlast_reg <= now_reg - TIME_W'(div_r);
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                    newlast_reg <= last_fired_reg + mul_p;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_reg.rebased        <= rebased_reg;
                    out_reg.skipped_count  <= skipped_reg;
                    out_reg.new_last_fired <= newlast_reg;
                    if (count_reg == '0)
                    begin
                        out_reg.stamp_time   <= '0;
                        out_reg.stamp_valid  <= 1'b0;
                        out_reg.last_of_poll <= 1'b1;
                    end
                    else
                    begin
                        stamp_reg            <= stamp_next;
                        out_reg.stamp_time   <= stamp_next;
                        out_reg.stamp_valid  <= 1'b1;
                        out_reg.last_of_poll <= last_stamp;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cfg.ready  = 1'b1;
    assign poll.ready = state_reg == ST_IDLE;

    assign result.valid          = out_valid_reg;
    assign result.stamp_time     = out_reg.stamp_time;
    assign result.stamp_valid    = out_reg.stamp_valid;
    assign result.last_of_poll   = out_reg.last_of_poll;
    assign result.rebased        = out_reg.rebased;
    assign result.skipped_count  = out_reg.skipped_count;
    assign result.new_last_fired = out_reg.new_last_fired;

endmodule

FILE: rtl/pcs_div.sv
// Bit-serial restoring divider: elapsed time over period interval.
module pcs_div import pcs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  time_t     dividend,
    input  interval_t divisor,
    output logic      done,
    output time_t     quotient,
    output interval_t remainder
);

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TIME_W - 1);

    time_t            dq_reg;
    interval_t        rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [INTERVAL_W:0] trial;
    logic [INTERVAL_W:0] diff;
    logic                ge;

    // shift one dividend bit into the partial remainder each cycle
    assign trial = {rem_reg, dq_reg[TIME_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[TIME_W-2:0], ge};
            rem_reg <= ge ? diff[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/pcs_mul.sv
// Bit-serial shift-add multiply of the interval by the boundary clamp.
module pcs_mul import pcs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  interval_t multiplicand,
    output logic      done,
    output time_t     product
);

    localparam int CNT_W = $clog2(SKIP_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SKIP_W - 1);

    time_t            mcand_reg;
    skip_t            mplier_reg;
    time_t            acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product is kept modulo 2^40, matching the stored time width
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= {{(TIME_W-INTERVAL_W){1'b0}}, multiplicand};
            mplier_reg <= BOUNDARY_CLAMP;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[TIME_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[SKIP_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/pcs_checker.sv
// Port-level assertions for the periodic catch-up scheduler, bound to the top level.
module pcs_checker import pcs_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  poll_valid,
    input logic  poll_ready,
    input logic  res_valid,
    input logic  res_ready,
    input time_t res_stamp_time,
    input logic  res_stamp_valid,
    input logic  res_last_of_poll,
    input logic  res_rebased,
    input skip_t res_skipped_count
);

    // a held word stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // a poll in flight blocks the next one
    a_busy_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && poll_ready |=> !poll_ready)
        else $error("poll accepted while previous poll still in flight");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stamp_valid |-> res_last_of_poll && res_stamp_time == '0)
        else $error("status word not final or carries a stamp time");

    a_rebase_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rebased |-> !res_stamp_valid && res_skipped_count == '0)
        else $error("rebase word carries stamp or skip count");

endmodule

bind periodic_catchup_scheduler pcs_checker u_pcs_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .poll_valid        (poll.valid),
    .poll_ready        (poll.ready),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .res_stamp_time    (result.stamp_time),
    .res_stamp_valid   (result.stamp_valid),
    .res_last_of_poll  (result.last_of_poll),
    .res_rebased       (result.rebased),
    .res_skipped_count (result.skipped_count)
);

FILE: verif/periodic_catchup_scheduler_test.sv
// Testbench for the periodic catch-up scheduler: directed and random polls, checked per word.
module periodic_catchup_scheduler_test import pcs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    QUEUE_DEPTH  = 16;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    SETTLE       = 80;
    localparam time_t TIME_MAX     = '1;
    localparam longint unsigned CROSS_CLAMP = 64'd1000000000;
    localparam cfg_data_t ONE_UNIT = 32'h0001_0000;

    // Expected-word store plus a software copy of the scheduler state.
    class catchup_model;
        interval_t period;
        maxo_t     max_jobs;
        time_t     last_fired;
        result_t   due_words[$];
        int        errors;

        function new();
            period     = '0;
            max_jobs   = MAX_OUTSTANDING_RST;
            last_fired = '0;
            errors     = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, cfg_data_t value);
            if (idx == REG_PERIOD_INTERVAL)
                period = value;
            else if (idx == REG_MAX_OUTSTANDING)
                max_jobs = value[MAXO_W-1:0];
        endfunction

        function void push_word(time_t stamp, logic has_stamp, logic is_last, logic reb,
                                longint unsigned skipped, time_t newlast);
            result_t w;
            w.stamp_time     = stamp;
            w.stamp_valid    = has_stamp;
            w.last_of_poll   = is_last;
            w.rebased        = reb;
            w.skipped_count  = skip_t'(skipped);
            w.new_last_fired = newlast;
            due_words.insert(due_words.size(), w);
        endfunction

        // Fire the crossed periods, up to the clamp and the free room, for one accepted poll.
        function void note_poll(time_t now, outst_t jobs);
            longint unsigned span, crossed, room, fired;
            time_t base, advanced;
            base = last_fired;
            if (period == '0)
            begin
                push_word('0, 1'b0, 1'b1, 1'b0, 0, base);
                return;
            end
            if (now < base)
            begin
                last_fired = now;
                push_word('0, 1'b0, 1'b1, 1'b1, 0, now);
                return;
            end
            span    = 64'(now - base);
            crossed = span / 64'(period);
            if (crossed == 0)
            begin
                push_word('0, 1'b0, 1'b1, 1'b0, 0, base);
                return;
            end
            if (crossed > CROSS_CLAMP)
                crossed = CROSS_CLAMP;
            room = (64'(jobs) >= 64'(max_jobs)) ? 0 : 64'(max_jobs) - 64'(jobs);
            if (room > QUEUE_DEPTH)
                room = QUEUE_DEPTH;
            fired      = (crossed < room) ? crossed : room;
            advanced   = time_t'(64'(base) + 64'(period) * crossed);
            last_fired = advanced;
            if (fired == 0)
            begin
                push_word('0, 1'b0, 1'b1, 1'b0, crossed, advanced);
                return;
            end
            for (longint unsigned i = 1; i <= fired; i++)
                push_word(time_t'(64'(base) + 64'(period) * i), 1'b1, i == fired, 1'b0,
                          crossed - fired, advanced);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(result_t got);
            result_t want;
            if (due_words.size() == 0)
            begin
                report($sformatf("word with nothing pending, stamp %h", got.stamp_time));
                return;
            end
            want = due_words.pop_front();
            if (got.stamp_time !== want.stamp_time)
                report($sformatf("stamp_time %h, want %h", got.stamp_time, want.stamp_time));
            if (got.stamp_valid !== want.stamp_valid)
                report($sformatf("stamp_valid %b, want %b", got.stamp_valid, want.stamp_valid));
            if (got.last_of_poll !== want.last_of_poll)
                report($sformatf("last_of_poll %b, want %b", got.last_of_poll,
                                 want.last_of_poll));
            if (got.rebased !== want.rebased)
                report($sformatf("rebased %b, want %b", got.rebased, want.rebased));
            if (got.skipped_count !== want.skipped_count)
                report($sformatf("skipped_count %0d, want %0d", got.skipped_count,
                                 want.skipped_count));
            if (got.new_last_fired !== want.new_last_fired)
                report($sformatf("new_last_fired %h, want %h", got.new_last_fired,
                                 want.new_last_fired));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   idle_pct;
    bit   hold_req;
    bit   hold_done;

    catchup_model model;

    pcs_cfg_if    cfg_ch ();
    pcs_poll_if   poll_ch ();
    pcs_result_if res_ch ();

    periodic_catchup_scheduler #(
        .QUEUE_LIMIT (QUEUE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .poll   (poll_ch),
        .result (res_ch)
    );

    always #10ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.stamp_time     = res_ch.stamp_time;
            got.stamp_valid    = res_ch.stamp_valid;
            got.last_of_poll   = res_ch.last_of_poll;
            got.rebased        = res_ch.rebased;
            got.skipped_count  = res_ch.skipped_count;
            got.new_last_fired = res_ch.new_last_fired;
            model.check_word(got);
        end
    end

    // Result sink: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 3)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        model.set_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_poll(time_t now, outst_t jobs);
        @(negedge clk);
        poll_ch.valid             <= 1'b1;
        poll_ch.now_time          <= now;
        poll_ch.outstanding_count <= jobs;
        do @(posedge clk); while (poll_ch.ready !== 1'b1);
        model.note_poll(now, jobs);
    endtask

    task automatic sender_gap();
        int n;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            n = $urandom_range(1, 13);
            @(negedge clk);
            poll_ch.valid <= 1'b0;
            repeat (n - 1) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        poll_ch.valid <= 1'b0;
        while (model.due_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(cfg_data_t interval, cfg_data_t jobs_cap);
        drain_results();
        write_reg(REG_PERIOD_INTERVAL, interval);
        write_reg(REG_MAX_OUTSTANDING, jobs_cap);
    endtask

    // Time a given number of periods past the stored boundary.
    function automatic time_t ahead(longint unsigned periods, longint unsigned extra);
        return time_t'(64'(model.last_fired) + periods * 64'(model.period) + extra);
    endfunction

    task automatic random_poll();
        int              pick;
        longint unsigned k, frac, target;
        time_t           now;
        outst_t          jobs;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0)
            jobs = outst_t'($urandom_range(0, int'(model.max_jobs) + 2));
        else
            jobs = outst_t'($urandom_range(0, 255));
        if (pick < 80)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
            frac = (model.period > 1) ? $urandom_range(0, model.period - 1) : 0;
            target = 64'(model.last_fired) + k * 64'(model.period) + frac;
            if (target > 64'(TIME_MAX))
                target = {$urandom, $urandom} % (64'(model.last_fired) + 1);
            now = time_t'(target);
        end
        else if (pick < 90 && model.last_fired != '0)
            now = time_t'({$urandom, $urandom} % 64'(model.last_fired));
        else
            now = time_t'({$urandom, $urandom});
        send_poll(now, jobs);
    endtask

    initial
    begin
        cfg_data_t interval, jobs_cap;
        model    = new();
        idle_pct = 20;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = REG_PERIOD_INTERVAL;
        cfg_ch.data               = '0;
        poll_ch.valid             = 1'b0;
        poll_ch.now_time          = '0;
        poll_ch.outstanding_count = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: zero interval gives status words only
        send_poll('0, 8'd0);
        send_poll(TIME_MAX, 8'd255);

        // one time unit per period, room of four
        configure(ONE_UNIT, 32'd4);
        send_poll(ahead(0, 32'h8000), 8'd0);
        send_poll(ahead(3, 0), 8'd0);
        send_poll(ahead(6, 5), 8'd1);
        send_poll(ahead(2, 0), 8'd4);
        send_poll(ahead(5, 0), 8'd255);
        send_poll(40'h1234, 8'd0);
        send_poll(ahead(4, 0), 8'd0);

        // smallest interval: backlog beyond the clamp
        configure(32'd1, 32'd16);
        send_poll(ahead(2000000000, 0), 8'd0);
        send_poll(ahead(1000000000, 0), 8'd0);
        send_poll(ahead(16, 0), 8'd0);
        send_poll(ahead(16, 0), 8'd16);

        // largest interval, no room at all
        configure(32'hFFFF_FFFF, 32'd0);
        send_poll(TIME_MAX, 8'd0);
        send_poll('0, 8'd0);
        send_poll(TIME_MAX, 8'd0);

        configure(32'd0, 32'd16);
        send_poll(40'h55_5555_5555, 8'd7);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 4)
                0: interval = $urandom_range(1, 255);
                1: interval = ONE_UNIT * $urandom_range(1, 8);
                2: interval = $urandom;
                default: interval = $urandom_range(32'h100, 32'hF_FFFF);
            endcase
            if (interval == '0)
                interval = ONE_UNIT;
            if (phase == 1)
                jobs_cap = 32'd16;
            else if (phase == 4)
                jobs_cap = 32'd1;
            else
                jobs_cap = $urandom_range(0, 16);
            configure(interval, jobs_cap);
            idle_pct = (phase == 5) ? 0 : 20;
            for (int i = 0; i < 26; i++)
            begin
                if (phase == 2 && i == 8)
                    hold_req = 1'b1;
                if (phase == 3 && i == 13)
                    drain_results();
                random_poll();
                sender_gap();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
